/* hdl/ultrasonic_range_brake_monitor_unit_assert.svh */
// assertion macros for the top-level rtl file
`ifndef ULTRASONIC_RANGE_BRAKE_MONITOR_UNIT_ASSERT_SVH
`define ULTRASONIC_RANGE_BRAKE_MONITOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define URBM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("urbm check failed");
`define URBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("urbm check failed");
`else
`define URBM_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define URBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/urbm_pkg.sv */
`default_nettype none

package urbm_pkg;

  localparam int REG_W      = 26;
  localparam int SCALE_W    = 16;
  localparam int MM_W       = 16;
  localparam int DIST_W     = 22;
  localparam int EVENT_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HIGH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HIGH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_ON     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_OFF    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP          = 3'd7;

  // reset values of the registers
  localparam logic [REG_W-1:0]   RST_TRIG_LOW     = 26'd2000;
  localparam logic [REG_W-1:0]   RST_TRIG_HIGH    = 26'd30000;
  localparam logic [REG_W-1:0]   RST_RISE_TIMEOUT = 26'd300000;
  localparam logic [REG_W-1:0]   RST_MAX_HIGH     = 26'd45000000;
  localparam logic [SCALE_W-1:0] RST_SCALE        = 16'd3714;
  localparam logic [MM_W-1:0]    RST_BRAKE_ON     = 16'd100;
  localparam logic [MM_W-1:0]    RST_BRAKE_OFF    = 16'd120;
  localparam logic [REG_W-1:0]   RST_GAP          = 26'd15000000;

  // outcome of one finished measurement
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              brake;
    logic              bell;
  } urbm_fin_t;

endpackage

`default_nettype wire

/* hdl/ultrasonic_range_brake_monitor_unit.sv */
`default_nettype none
`include "ultrasonic_range_brake_monitor_unit_assert.svh"

// Ultrasonic echo timer with brake monitor. Every request carries one clock tick's sampled
// echo level and yields exactly one result: trigger drive, a done strobe with the new distance,
// the hysteresis brake flag, a doorbell strobe and the wrapping braked-event count. Requests
// are taken one per cycle sustained while out_stall is low; a request is held in the input
// register until the measurement sequencer with the width-times-scale multiply and brake
// compare updates state and the result register from it. The input register lets a new
// request in while a result still waits on out_stall. Configuration writes take effect on
// the next edge and should be done while no request is in flight.
module ultrasonic_range_brake_monitor_unit #(
  parameter int COUNT_WIDTH = 26
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [urbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [urbm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_echo_level,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_trig_level,
  output logic                                 out_measure_done,
  output logic [urbm_pkg::DIST_W-1:0]          out_distance_mm,
  output logic                                 out_brake_flag,
  output logic                                 out_doorbell_pulse,
  output logic [urbm_pkg::EVENT_W-1:0]         out_event_count
);
  import urbm_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] TICK_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    PH_LOW   = 3'd0,
    PH_HIGH  = 3'd1,
    PH_WAIT  = 3'd2,
    PH_COUNT = 3'd3,
    PH_GAP   = 3'd4
  } phase_t;

  function automatic logic [COUNT_WIDTH-1:0] lim(input logic [REG_W-1:0] v);
    logic [COUNT_WIDTH-1:0] r;
    r = (32'(v) > 32'(TICK_MAX)) ? TICK_MAX : COUNT_WIDTH'(v);
    return r;
  endfunction

  // configuration
  logic [REG_W-1:0]   trig_low_r, trig_high_r, rise_timeout_r, max_high_r, gap_r;
  logic [SCALE_W-1:0] scale_r;
  logic [MM_W-1:0]    brake_on_r, brake_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_low_r     <= RST_TRIG_LOW;
      trig_high_r    <= RST_TRIG_HIGH;
      rise_timeout_r <= RST_RISE_TIMEOUT;
      max_high_r     <= RST_MAX_HIGH;
      scale_r        <= RST_SCALE;
      brake_on_r     <= RST_BRAKE_ON;
      brake_off_r    <= RST_BRAKE_OFF;
      gap_r          <= RST_GAP;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TRIG_LOW:     trig_low_r     <= cfg_data[REG_W-1:0];
        CFG_TRIG_HIGH:    trig_high_r    <= cfg_data[REG_W-1:0];
        CFG_RISE_TIMEOUT: rise_timeout_r <= cfg_data[REG_W-1:0];
        CFG_MAX_HIGH:     max_high_r     <= cfg_data[REG_W-1:0];
        CFG_SCALE:        scale_r        <= cfg_data[SCALE_W-1:0];
        CFG_BRAKE_ON:     brake_on_r     <= cfg_data[MM_W-1:0];
        CFG_BRAKE_OFF:    brake_off_r    <= cfg_data[MM_W-1:0];
        CFG_GAP:          gap_r          <= cfg_data[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic in_valid_r, echo_r;
  logic out_valid_r;
  logic can_load, advance, in_accept;

  assign can_load  = !out_valid_r || !out_stall;
  assign advance   = in_valid_r && can_load;
  assign in_stall  = in_valid_r && !can_load;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      echo_r <= in_echo_level;
    end
  end

  // sequencer state
  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] ticks_r, ticks_nxt, ticks_inc;
  logic [COUNT_WIDTH-1:0] width_r, width_nxt, fin_width;
  logic [DIST_W-1:0]      dist_r;
  logic                   brake_r;
  logic [EVENT_W-1:0]     events_r;
  logic                   trig_r, trig_nxt, done_r, done_nxt, bell_r;
  logic [COUNT_WIDTH-1:0] gap_lim;
  urbm_fin_t              fin;

  assign ticks_inc = (ticks_r != TICK_MAX) ? ticks_r + 1'b1 : ticks_r;
  assign gap_lim   = lim(gap_r);
  // a rise timeout finishes with zero width
  assign fin_width = (phase_r == PH_WAIT) ? '0 : width_r;

  urbm_brake #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_brake (
    .width        (fin_width),
    .scale        (scale_r),
    .brake_on_mm  (brake_on_r),
    .brake_off_mm (brake_off_r),
    .brake_cur    (brake_r),
    .fin          (fin)
  );

  always_comb begin
    phase_nxt = phase_r;
    ticks_nxt = ticks_r;
    width_nxt = width_r;
    trig_nxt  = 1'b0;
    done_nxt  = 1'b0;
    unique case (phase_r)
      PH_LOW: begin
        ticks_nxt = ticks_inc;
        if (ticks_inc >= lim(trig_low_r)) begin
          phase_nxt = PH_HIGH;
          ticks_nxt = '0;
        end
      end
      PH_HIGH: begin
        trig_nxt  = 1'b1;
        ticks_nxt = ticks_inc;
        if (ticks_inc >= lim(trig_high_r)) begin
          phase_nxt = PH_WAIT;
          ticks_nxt = '0;
        end
      end
      PH_WAIT: begin
        if (echo_r) begin
          // first high sample counts with the tick counter restarted at one
          if (COUNT_WIDTH'(1) >= lim(max_high_r)) begin
            done_nxt = 1'b1;
          end else begin
            phase_nxt = PH_COUNT;
            ticks_nxt = COUNT_WIDTH'(1);
            width_nxt = COUNT_WIDTH'(1);
          end
        end else begin
          ticks_nxt = ticks_inc;
          if (ticks_inc >= lim(rise_timeout_r)) begin
            done_nxt = 1'b1;
          end
        end
      end
      PH_COUNT: begin
        if (!echo_r || (ticks_inc >= lim(max_high_r))) begin
          done_nxt = 1'b1;
        end else begin
          ticks_nxt = ticks_inc;
          width_nxt = (width_r != TICK_MAX) ? width_r + 1'b1 : width_r;
        end
      end
      PH_GAP: begin
        ticks_nxt = ticks_inc;
        if (ticks_inc >= gap_lim) begin
          phase_nxt = PH_LOW;
          ticks_nxt = '0;
        end
      end
      default: begin
        phase_nxt = PH_LOW;
        ticks_nxt = '0;
      end
    endcase
    if (done_nxt) begin
      width_nxt = fin_width;
      ticks_nxt = '0;
      phase_nxt = (gap_lim == '0) ? PH_LOW : PH_GAP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LOW;
      ticks_r     <= '0;
      width_r     <= '0;
      dist_r      <= '0;
      brake_r     <= 1'b0;
      events_r    <= '0;
      trig_r      <= 1'b0;
      done_r      <= 1'b0;
      bell_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        phase_r     <= phase_nxt;
        ticks_r     <= ticks_nxt;
        width_r     <= width_nxt;
        trig_r      <= trig_nxt;
        done_r      <= done_nxt;
        bell_r      <= done_nxt && fin.bell;
        out_valid_r <= 1'b1;
        if (done_nxt) begin
          dist_r  <= fin.distance;
          brake_r <= fin.brake;
          if (fin.bell) begin
            events_r <= events_r + 1'b1;
          end
        end
      end else if (!can_load) begin
        out_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // state only moves on advance, so it doubles as the held result
  assign out_valid          = out_valid_r;
  assign out_trig_level     = trig_r;
  assign out_measure_done   = done_r;
  assign out_distance_mm    = dist_r;
  assign out_brake_flag     = brake_r;
  assign out_doorbell_pulse = bell_r;
  assign out_event_count    = events_r;

  `URBM_ASSERT_SAME(a_bell_needs_brake, clk, rst_n, out_valid_r && bell_r, brake_r)
  `URBM_ASSERT_SAME(a_bell_needs_done, clk, rst_n, out_valid_r && bell_r, done_r)
  `URBM_ASSERT_SAME(a_trig_not_done, clk, rst_n, out_valid_r && trig_r, !done_r)
  `URBM_ASSERT_NEXT(a_event_step, clk, rst_n, advance && done_nxt && fin.bell,
                    events_r == $past(events_r) + 1'b1)

endmodule

`default_nettype wire

/* hdl/urbm_brake.sv */
`default_nettype none

module urbm_brake #(
  parameter int COUNT_WIDTH = 26
) (
  input  wire logic [COUNT_WIDTH-1:0]       width,
  input  wire logic [urbm_pkg::SCALE_W-1:0] scale,
  input  wire logic [urbm_pkg::MM_W-1:0]    brake_on_mm,
  input  wire logic [urbm_pkg::MM_W-1:0]    brake_off_mm,
  input  wire logic                         brake_cur,
  output urbm_pkg::urbm_fin_t               fin
);
  import urbm_pkg::*;

  localparam int PROD_W = COUNT_WIDTH + SCALE_W;

  logic [PROD_W-1:0]      prod;
  logic [COUNT_WIDTH-1:0] dist_raw;
  logic [DIST_W-1:0]      dist_sat;
  logic                   brake_nxt;

  // q0.16 scale, keep integer part
  assign prod     = PROD_W'(width) * PROD_W'(scale);
  assign dist_raw = prod[PROD_W-1:SCALE_W];
  assign dist_sat = (32'(dist_raw) > 32'(DIST_MAX)) ? DIST_MAX : DIST_W'(dist_raw);

  always_comb begin
    brake_nxt = brake_cur;
    if (!brake_cur && (dist_sat != '0) && (dist_sat < DIST_W'(brake_on_mm))) begin
      brake_nxt = 1'b1;
    end else if (brake_cur && (dist_sat >= DIST_W'(brake_off_mm))) begin
      brake_nxt = 1'b0;
    end
  end

  assign fin.distance = dist_sat;
  assign fin.brake    = brake_nxt;
  assign fin.bell     = brake_nxt;

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import urbm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 80;

  typedef enum logic [2:0] {
    SEQ_TRIG_LOW  = 3'd0,
    SEQ_TRIG_HIGH = 3'd1,
    SEQ_WAIT_RISE = 3'd2,
    SEQ_COUNT     = 3'd3,
    SEQ_GAP       = 3'd4
  } seq_phase_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic              trig;
    logic              done;
    logic [DIST_W-1:0] dist_mm;
    logic              brake;
    logic              bell;
    logic [EVENT_W-1:0] events;
  } echo_result_t;

  typedef struct {
    logic [REG_W-1:0]   trig_low;
    logic [REG_W-1:0]   trig_high;
    logic [REG_W-1:0]   rise_to;
    logic [REG_W-1:0]   max_high;
    logic [SCALE_W-1:0] scale;
    logic [MM_W-1:0]    brake_on;
    logic [MM_W-1:0]    brake_off;
    logic [REG_W-1:0]   gap;
  } range_cfg_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TRIG_LOW;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_echo_level = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_trig_level;
  logic out_measure_done;
  logic [DIST_W-1:0] out_distance_mm;
  logic out_brake_flag;
  logic out_doorbell_pulse;
  logic [EVENT_W-1:0] out_event_count;

  ultrasonic_range_brake_monitor_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_echo_level      (in_echo_level),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_trig_level     (out_trig_level),
    .out_measure_done   (out_measure_done),
    .out_distance_mm    (out_distance_mm),
    .out_brake_flag     (out_brake_flag),
    .out_doorbell_pulse (out_doorbell_pulse),
    .out_event_count    (out_event_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // configuration as the sequencer sees it
  logic [REG_W-1:0]   low_len   = RST_TRIG_LOW;
  logic [REG_W-1:0]   high_len  = RST_TRIG_HIGH;
  logic [REG_W-1:0]   rise_len  = RST_RISE_TIMEOUT;
  logic [REG_W-1:0]   max_high  = RST_MAX_HIGH;
  logic [SCALE_W-1:0] scale_q16 = RST_SCALE;
  logic [MM_W-1:0]    brake_on  = RST_BRAKE_ON;
  logic [MM_W-1:0]    brake_off = RST_BRAKE_OFF;
  logic [REG_W-1:0]   gap_len   = RST_GAP;

  // sequencer state
  seq_phase_t         seq           = SEQ_TRIG_LOW;
  logic [REG_W-1:0]   phase_cnt     = '0;
  logic [REG_W-1:0]   echo_width    = '0;
  logic [DIST_W-1:0]  dist_reg      = '0;
  logic               brake_reg     = 1'b0;
  logic [EVENT_W-1:0] braked_events = '0;

  logic         echo_q[$];
  echo_result_t expected_q[$];
  int           mismatches = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  bit           hold_req = 1'b0;
  bit           hold_taken = 1'b0;
  int           hold_left = 0;
  int           quiet_cycles = 0;

  function automatic void bump_count();
    if (phase_cnt != '1) phase_cnt++;
  endfunction

  function automatic logic finish_measurement();
    logic [63:0] prod;
    prod = (64'(echo_width) * 64'(scale_q16)) >> 16;
    dist_reg = (prod > 64'(DIST_MAX)) ? DIST_MAX : prod[DIST_W-1:0];
    if (!brake_reg && dist_reg != '0 && dist_reg < brake_on) brake_reg = 1'b1;
    else if (brake_reg && dist_reg >= brake_off) brake_reg = 1'b0;
    if (brake_reg) braked_events = braked_events + 1'b1;
    phase_cnt = '0;
    seq = (gap_len == '0) ? SEQ_TRIG_LOW : SEQ_GAP;
    return brake_reg;
  endfunction

  // returns 1 when the sample ends the measurement at the width limit
  function automatic logic take_high_sample();
    bump_count();
    if (phase_cnt >= max_high) return 1'b1;
    if (echo_width != '1) echo_width++;
    return 1'b0;
  endfunction

  function automatic echo_result_t range_step(logic echo);
    echo_result_t r;
    r = '0;
    case (seq)
      SEQ_TRIG_LOW: begin
        bump_count();
        if (phase_cnt >= low_len) begin
          seq = SEQ_TRIG_HIGH;
          phase_cnt = '0;
        end
      end
      SEQ_TRIG_HIGH: begin
        r.trig = 1'b1;
        bump_count();
        if (phase_cnt >= high_len) begin
          seq = SEQ_WAIT_RISE;
          phase_cnt = '0;
        end
      end
      SEQ_WAIT_RISE: begin
        if (echo) begin
          seq = SEQ_COUNT;
          phase_cnt = '0;
          echo_width = '0;
          if (take_high_sample()) begin
            r.done = 1'b1;
            r.bell = finish_measurement();
          end
        end else begin
          bump_count();
          if (phase_cnt >= rise_len) begin
            echo_width = '0;
            r.done = 1'b1;
            r.bell = finish_measurement();
          end
        end
      end
      SEQ_COUNT: begin
        if (!echo || take_high_sample()) begin
          r.done = 1'b1;
          r.bell = finish_measurement();
        end
      end
      SEQ_GAP: begin
        bump_count();
        if (phase_cnt >= gap_len) begin
          seq = SEQ_TRIG_LOW;
          phase_cnt = '0;
        end
      end
      default: begin
        seq = SEQ_TRIG_LOW;
        phase_cnt = '0;
      end
    endcase
    r.dist_mm = dist_reg;
    r.brake = brake_reg;
    r.events = braked_events;
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) expected_q.push_back(range_step(in_echo_level));
      if (!in_valid || !in_stall) begin
        if (echo_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_echo_level <= echo_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result stall, with one long hold-off to back up the input
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    echo_result_t got;
    echo_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_trig_level, out_measure_done, out_distance_mm, out_brake_flag,
             out_doorbell_pulse, out_event_count};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing outstanding: trig=%0b done=%0b dist=%0d",
                   $time, got.trig, got.done, got.dist_mm);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch exp trig=%0b done=%0b dist=%0d brake=%0b bell=%0b ev=%0d",
                     $time, want.trig, want.done, want.dist_mm, want.brake, want.bell,
                     want.events);
            $display("%0t:          got trig=%0b done=%0b dist=%0d brake=%0b bell=%0b ev=%0d",
                     $time, got.trig, got.done, got.dist_mm, got.brake, got.bell,
                     got.events);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL ultrasonic_range_brake_monitor_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_TRIG_LOW:     low_len = data;
      CFG_TRIG_HIGH:    high_len = data;
      CFG_RISE_TIMEOUT: rise_len = data;
      CFG_MAX_HIGH:     max_high = data;
      CFG_SCALE:        scale_q16 = data[SCALE_W-1:0];
      CFG_BRAKE_ON:     brake_on = data[MM_W-1:0];
      CFG_BRAKE_OFF:    brake_off = data[MM_W-1:0];
      CFG_GAP:          gap_len = data;
      default: ;
    endcase
  endtask

  // 16-bit registers get junk in the unused upper data bits
  task automatic apply_cfg(range_cfg_t c);
    logic [CFG_DATA_W-SCALE_W-1:0] junk;
    junk = (CFG_DATA_W-SCALE_W)'($urandom);
    write_reg(CFG_TRIG_LOW, c.trig_low);
    write_reg(CFG_TRIG_HIGH, c.trig_high);
    write_reg(CFG_RISE_TIMEOUT, c.rise_to);
    write_reg(CFG_MAX_HIGH, c.max_high);
    write_reg(CFG_SCALE, {junk, c.scale});
    write_reg(CFG_BRAKE_ON, {~junk, c.brake_on});
    write_reg(CFG_BRAKE_OFF, {junk, c.brake_off});
    write_reg(CFG_GAP, c.gap);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_idling(idle_mode_t m);
    case (m)
      IDLE_NONE: begin send_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 81; stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 81; end
      IDLE_BOTH: begin send_idle_pct = 25; stall_pct = 25; end
      default:   begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // alternating low and high echo runs with the odd glitch sample
  task automatic queue_echo(int count, int low_run, int high_run);
    int left;
    int len;
    logic lvl;
    left = count;
    lvl = 1'b0;
    while (left > 0) begin
      len = lvl ? $urandom_range(1, high_run) : $urandom_range(1, low_run);
      if (len > left) len = left;
      repeat (len) begin
        echo_q.push_back(($urandom_range(0, 19) == 0) ? ~lvl : lvl);
        left--;
      end
      lvl = ~lvl;
    end
  endtask

  task automatic drain();
    while (echo_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(range_cfg_t c, idle_mode_t m, int count, int low_run,
                           int high_run);
    apply_cfg(c);
    set_idling(m);
    queue_echo(count, low_run, high_run);
    drain();
  endtask

  initial begin
    range_cfg_t c;
    logic [7:0] boot_echo;
    logic [19:0] walk_echo;
    boot_echo = 8'b1011_0010;
    // timeout, width limit, echo ignored while triggering, width one, low-sample end
    walk_echo = 20'b0000_0001_1111_0100_0111;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: the trigger low phase runs far beyond these requests
    for (int i = 7; i >= 0; i--) echo_q.push_back(boot_echo[i]);
    drain();

    c = '{trig_low: 1, trig_high: 1, rise_to: 4, max_high: 3, scale: 16'hFFFF,
          brake_on: 2, brake_off: 3, gap: 0};
    apply_cfg(c);
    for (int i = 19; i >= 0; i--) echo_q.push_back(walk_echo[i]);
    drain();

    // every length register zero
    c = '{trig_low: 0, trig_high: 0, rise_to: 0, max_high: 0, scale: 16'h0000,
          brake_on: 0, brake_off: 0, gap: 0};
    run_phase(c, IDLE_SEND, 40, 4, 4);

    // largest gap, then largest trigger high, then largest trigger low; each
    // stretch is released by the next write
    c = '{trig_low: 1, trig_high: 1, rise_to: 8, max_high: 20, scale: 16'hFFFF,
          brake_on: 5, brake_off: 9, gap: '1};
    run_phase(c, IDLE_RECV, 40, 10, 12);
    c.gap = 1;
    c.trig_high = '1;
    run_phase(c, IDLE_BOTH, 40, 10, 12);
    c.trig_high = 2;
    c.gap = 2;
    c.trig_low = '1;
    run_phase(c, IDLE_NONE, 40, 10, 12);

    for (int p = 0; p < 6; p++) begin
      c.trig_low = REG_W'($urandom_range(0, 4));
      c.trig_high = REG_W'($urandom_range(0, 4));
      c.rise_to = REG_W'($urandom_range(1, 30));
      c.max_high = REG_W'($urandom_range(0, 40));
      c.scale = (p % 2 == 0) ? 16'hFFFF : 16'($urandom_range(16384, 65535));
      c.brake_on = MM_W'($urandom_range(0, 35));
      c.brake_off = MM_W'($urandom_range(0, 35));
      c.gap = REG_W'($urandom_range(0, 6));
      if (p == 1) begin
        c.rise_to = '1;
        c.max_high = '1;
        c.brake_on = '1;
        c.brake_off = '1;
      end
      apply_cfg(c);
      set_idling(idle_mode_t'(p % 4));
      if (p == 4) hold_req = 1'b1;
      queue_echo(95, 30, 45);
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS ultrasonic_range_brake_monitor_unit");
    end else begin
      $display("FAIL ultrasonic_range_brake_monitor_unit");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/urbm_pkg.sv
hdl/urbm_brake.sv
hdl/ultrasonic_range_brake_monitor_unit.sv
tb/testbench.sv
